/* hw/rtl/lzsq_pkg.sv */
// Shared types, codes and the distance table function for the square-table LZ decompressor.
package lzsq_pkg;

    localparam int HISTORY_DEPTH_DEF    = 32768;
    localparam int LENGTH_BITS_DEF      = 24;
    localparam int BYTES_PER_RESULT_DEF = 4;

    localparam int CFG_WIDTH       = 24;
    localparam int CFG_INDEX_WIDTH = 1;
    localparam int DIST_WIDTH      = 15;

    localparam logic [CFG_INDEX_WIDTH-1:0] REG_SRC_LENGTH = 1'b0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_DST_LENGTH = 1'b1;

    localparam logic [1:0] STATUS_RUNNING = 2'd0;
    localparam logic [1:0] STATUS_DONE    = 2'd1;
    localparam logic [1:0] STATUS_ERROR   = 2'd2;

    localparam logic [1:0] PH_FIRST   = 2'd0;
    localparam logic [1:0] PH_SECOND  = 2'd1;
    localparam logic [1:0] PH_LITERAL = 2'd2;

    typedef struct packed {
        logic       start_stream;
        logic [7:0] in_byte;
    } lzsq_in_t;

    typedef struct packed {
        logic [31:0] out_bytes;
        logic [2:0]  byte_count;
        logic        last_of_run;
        logic [1:0]  status;
        logic [23:0] produced_count;
    } lzsq_out_t;

    // floor(b*b/2), with 1 for b of one
    function automatic logic [DIST_WIDTH-1:0] distance_of(input logic [7:0] b);
        logic [15:0] sq;
        sq = 16'(b) * 16'(b);
        if (b == 8'd1) begin
            return DIST_WIDTH'(1);
        end
        return sq[15:1];
    endfunction

endpackage

/* hw/rtl/lz_square_table_decompressor.sv */
// Top level of the square-table LZ decompressor: parser, history memory and result packer.
// Token and literal bytes: taken only in S_IDLE; S_EVAL registers the result on m_, waiting only
//   while m_ready holds the output stage. Back reference of n bytes: one history byte a cycle
//   unless m_ready holds a full result, through the single read port of the history memory;
//   results of up to BYTES_PER_RESULT bytes leave as packed.
// Reset (aresetn, synchronous, active low) clears the parser, positions, status and length
//   registers at once; the history memory is not cleared and needs no clearing pass.
module lz_square_table_decompressor #(
    parameter int HISTORY_DEPTH    = lzsq_pkg::HISTORY_DEPTH_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  lzsq_pkg::lzsq_in_t                   s_item,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output lzsq_pkg::lzsq_out_t                  m_item,
    input  logic                                 cfg_wen,
    input  logic [lzsq_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [lzsq_pkg::CFG_WIDTH-1:0]       cfg_wdata
);

    localparam int LENGTH_BITS      = lzsq_pkg::LENGTH_BITS_DEF;
    localparam int BYTES_PER_RESULT = lzsq_pkg::BYTES_PER_RESULT_DEF;

    localparam int L  = LENGTH_BITS;
    localparam int HB = $clog2(HISTORY_DEPTH);
    localparam int PB = 8 * BYTES_PER_RESULT;
    localparam int CW = $clog2(BYTES_PER_RESULT + 1);
    localparam int DW = lzsq_pkg::DIST_WIDTH;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EVAL = 2'd1;
    localparam logic [1:0] S_COPY = 2'd2;

    function automatic logic [1:0] boundary(input logic [L-1:0] inp, input logic [L-1:0] outp,
                                            input logic [L-1:0] src, input logic [L-1:0] dst);
        if (dst == '0) begin
            return lzsq_pkg::STATUS_ERROR;
        end
        if (((L+1)'(inp) + (L+1)'(1) >= (L+1)'(src)) || (outp >= dst)) begin
            return lzsq_pkg::STATUS_DONE;
        end
        return lzsq_pkg::STATUS_RUNNING;
    endfunction

    function automatic logic [HB-1:0] hist_inc(input logic [HB-1:0] a);
        if (a == HB'(HISTORY_DEPTH - 1)) begin
            return '0;
        end
        return a + HB'(1);
    endfunction

    logic [7:0] history_mem [HISTORY_DEPTH];

    logic [1:0]          state_reg, state_next;
    logic                in_start_reg, in_start_next;
    logic [7:0]          in_byte_reg, in_byte_next;
    logic [1:0]          status_reg, status_next;
    logic [1:0]          phase_reg, phase_next;
    logic [L-1:0]        in_pos_reg, in_pos_next;
    logic [L-1:0]        out_pos_reg, out_pos_next;
    logic [HB-1:0]       wptr_reg, wptr_next;
    logic [7:0]          token_first_reg, token_first_next;
    logic [DW-1:0]       dist_reg, dist_next;
    logic [7:0]          literal_left_reg, literal_left_next;
    logic [L-1:0]        src_len_reg, src_len_next;
    logic [L-1:0]        dst_len_reg, dst_len_next;
    logic [HB-1:0]       rd_addr_reg, rd_addr_next;
    logic [7:0]          rd_left_reg, rd_left_next;
    logic [7:0]          wr_left_reg, wr_left_next;
    logic                b_valid_reg, b_valid_next;
    logic                fwd_one_reg, fwd_one_next;
    logic                any_done_reg, any_done_next;
    logic [7:0]          last_byte_reg, last_byte_next;
    logic [7:0]          rdata_reg;
    logic [PB-1:0]       pack_data_reg, pack_data_next;
    logic [CW-1:0]       pack_n_reg, pack_n_next;
    logic                m_valid_reg, m_valid_next;
    lzsq_pkg::lzsq_out_t m_item_reg, m_item_next;

    // evaluation of one accepted byte
    logic [1:0]          ev_st0, ev_ph0, ev_st1;
    logic [L-1:0]        ev_in0, ev_out0, ev_in1;
    logic [HB-1:0]       ev_wptr0;
    logic [7:0]          ev_tf0, ev_ll0;
    logic                lit_bad, copy_bad;
    logic [HB:0]         ev_diff;
    logic [HB-1:0]       ev_rd_start;
    logic [1:0]          ev_status, ev_phase;
    logic [L-1:0]        ev_in, ev_out;
    logic [HB-1:0]       ev_wptr;
    logic [7:0]          ev_tf, ev_ll;
    logic [DW-1:0]       ev_dist;
    logic                ev_emit, ev_copy;
    lzsq_pkg::lzsq_out_t ev_item;

    // copy datapath
    logic                out_free, completes, consume, rd_en;
    logic [7:0]          cp_byte;
    logic [PB-1:0]       pack_ins;
    logic [CW-1:0]       pack_cnt;
    logic                res_push;
    lzsq_pkg::lzsq_out_t res_item;
    logic                mem_we;
    logic [HB-1:0]       mem_waddr;
    logic [7:0]          mem_wdata;

    always_comb begin
        ev_st0   = in_start_reg ? lzsq_pkg::STATUS_RUNNING : status_reg;
        ev_ph0   = in_start_reg ? lzsq_pkg::PH_FIRST : phase_reg;
        ev_in0   = in_start_reg ? '0 : in_pos_reg;
        ev_out0  = in_start_reg ? '0 : out_pos_reg;
        ev_wptr0 = in_start_reg ? '0 : wptr_reg;
        ev_tf0   = in_start_reg ? 8'd0 : token_first_reg;
        ev_ll0   = in_start_reg ? 8'd0 : literal_left_reg;
        ev_in1   = ev_in0 + L'(1);

        lit_bad  = ((L+1)'(ev_in1) + (L+1)'(in_byte_reg) > (L+1)'(src_len_reg)) ||
                   ((L+1)'(ev_out0) + (L+1)'(in_byte_reg) > (L+1)'(dst_len_reg));
        copy_bad = (dist_reg == '0) || (L'(dist_reg) > ev_out0) ||
                   ((L+1)'(ev_out0) + (L+1)'(in_byte_reg) > (L+1)'(dst_len_reg));

        ev_diff = (HB+1)'(ev_wptr0) - (HB+1)'(dist_reg);
        if (ev_diff[HB]) begin
            ev_diff = ev_diff + (HB+1)'(HISTORY_DEPTH);
        end
        ev_rd_start = ev_diff[HB-1:0];

        if (ev_st0 == lzsq_pkg::STATUS_RUNNING && ev_ph0 == lzsq_pkg::PH_FIRST) begin
            ev_st1 = boundary(ev_in0, ev_out0, src_len_reg, dst_len_reg);
        end else begin
            ev_st1 = ev_st0;
        end

        ev_status = ev_st1;
        ev_phase  = ev_ph0;
        ev_in     = ev_in0;
        ev_out    = ev_out0;
        ev_wptr   = ev_wptr0;
        ev_tf     = ev_tf0;
        ev_ll     = ev_ll0;
        ev_dist   = dist_reg;
        ev_emit   = 1'b0;
        ev_copy   = 1'b0;

        if (ev_st1 == lzsq_pkg::STATUS_RUNNING) begin
            case (ev_ph0)
                lzsq_pkg::PH_FIRST: begin
                    ev_tf    = in_byte_reg;
                    ev_dist  = lzsq_pkg::distance_of(in_byte_reg);
                    ev_in    = ev_in1;
                    ev_phase = lzsq_pkg::PH_SECOND;
                end
                lzsq_pkg::PH_SECOND: begin
                    ev_in = ev_in1;
                    if (ev_tf0 == 8'd0) begin
                        if (lit_bad) begin
                            ev_status = lzsq_pkg::STATUS_ERROR;
                        end else if (in_byte_reg == 8'd0) begin
                            ev_phase  = lzsq_pkg::PH_FIRST;
                            ev_status = boundary(ev_in1, ev_out0, src_len_reg, dst_len_reg);
                        end else begin
                            ev_ll    = in_byte_reg;
                            ev_phase = lzsq_pkg::PH_LITERAL;
                        end
                    end else begin
                        if (copy_bad) begin
                            ev_status = lzsq_pkg::STATUS_ERROR;
                        end else begin
                            ev_phase  = lzsq_pkg::PH_FIRST;
                            ev_status = boundary(ev_in1, ev_out0 + L'(in_byte_reg),
                                                 src_len_reg, dst_len_reg);
                            ev_copy   = (in_byte_reg != 8'd0);
                        end
                    end
                end
                lzsq_pkg::PH_LITERAL: begin
                    ev_in   = ev_in1;
                    ev_emit = 1'b1;
                    ev_out  = ev_out0 + L'(1);
                    ev_wptr = hist_inc(ev_wptr0);
                    ev_ll   = (ev_ll0 != 8'd0) ? ev_ll0 - 8'd1 : 8'd0;
                    if (ev_ll0 <= 8'd1) begin
                        ev_phase  = lzsq_pkg::PH_FIRST;
                        ev_status = boundary(ev_in1, ev_out0 + L'(1), src_len_reg, dst_len_reg);
                    end
                end
                default: begin
                end
            endcase
        end

        ev_item.out_bytes      = ev_emit ? 32'(in_byte_reg) : 32'd0;
        ev_item.byte_count     = ev_emit ? 3'd1 : 3'd0;
        ev_item.last_of_run    = 1'b1;
        ev_item.status         = ev_status;
        ev_item.produced_count = 24'(ev_out);
    end

    always_comb begin
        out_free  = !m_valid_reg || m_ready;
        completes = (pack_n_reg == CW'(BYTES_PER_RESULT - 1)) || (wr_left_reg == 8'd1);
        consume   = (state_reg == S_COPY) && b_valid_reg && (!completes || out_free);
        rd_en     = (state_reg == S_COPY) && (rd_left_reg != 8'd0) && (!b_valid_reg || consume);
        cp_byte   = (fwd_one_reg && any_done_reg) ? last_byte_reg : rdata_reg;
        pack_cnt  = pack_n_reg + CW'(1);
        for (int i = 0; i < BYTES_PER_RESULT; i++) begin
            pack_ins[8*i +: 8] = (CW'(i) == pack_n_reg) ? cp_byte : pack_data_reg[8*i +: 8];
        end
    end

    always_comb begin
        state_next        = state_reg;
        in_start_next     = in_start_reg;
        in_byte_next      = in_byte_reg;
        status_next       = status_reg;
        phase_next        = phase_reg;
        in_pos_next       = in_pos_reg;
        out_pos_next      = out_pos_reg;
        wptr_next         = wptr_reg;
        token_first_next  = token_first_reg;
        dist_next         = dist_reg;
        literal_left_next = literal_left_reg;
        src_len_next      = src_len_reg;
        dst_len_next      = dst_len_reg;
        rd_addr_next      = rd_addr_reg;
        rd_left_next      = rd_left_reg;
        wr_left_next      = wr_left_reg;
        b_valid_next      = b_valid_reg;
        fwd_one_next      = fwd_one_reg;
        any_done_next     = any_done_reg;
        last_byte_next    = last_byte_reg;
        pack_data_next    = pack_data_reg;
        pack_n_next       = pack_n_reg;
        res_push          = 1'b0;
        res_item          = ev_item;
        mem_we            = 1'b0;
        mem_waddr         = wptr_reg;
        mem_wdata         = cp_byte;

        if (cfg_wen) begin
            unique case (cfg_index)
                lzsq_pkg::REG_SRC_LENGTH: src_len_next = L'(cfg_wdata);
                lzsq_pkg::REG_DST_LENGTH: dst_len_next = L'(cfg_wdata);
                default: begin
                end
            endcase
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    in_start_next = s_item.start_stream;
                    in_byte_next  = s_item.in_byte;
                    state_next    = S_EVAL;
                end
            end
            S_EVAL: begin
                if (ev_copy || out_free) begin
                    status_next       = ev_status;
                    phase_next        = ev_phase;
                    in_pos_next       = ev_in;
                    out_pos_next      = ev_out;
                    wptr_next         = ev_wptr;
                    token_first_next  = ev_tf;
                    dist_next         = ev_dist;
                    literal_left_next = ev_ll;
                    if (ev_copy) begin
                        rd_addr_next   = ev_rd_start;
                        rd_left_next   = in_byte_reg;
                        wr_left_next   = in_byte_reg;
                        b_valid_next   = 1'b0;
                        fwd_one_next   = (dist_reg == DW'(1));
                        any_done_next  = 1'b0;
                        pack_data_next = '0;
                        pack_n_next    = '0;
                        state_next     = S_COPY;
                    end else begin
                        res_push   = 1'b1;
                        mem_we     = ev_emit;
                        mem_waddr  = ev_wptr0;
                        mem_wdata  = in_byte_reg;
                        state_next = S_IDLE;
                    end
                end
            end
            S_COPY: begin
                if (rd_en) begin
                    rd_addr_next = hist_inc(rd_addr_reg);
                    rd_left_next = rd_left_reg - 8'd1;
                end
                b_valid_next = rd_en || (b_valid_reg && !consume);
                if (consume) begin
                    mem_we         = 1'b1;
                    wptr_next      = hist_inc(wptr_reg);
                    out_pos_next   = out_pos_reg + L'(1);
                    wr_left_next   = wr_left_reg - 8'd1;
                    last_byte_next = cp_byte;
                    any_done_next  = 1'b1;
                    if (completes) begin
                        res_push                = 1'b1;
                        res_item.out_bytes      = pack_ins[31:0];
                        res_item.byte_count     = 3'(pack_cnt);
                        res_item.last_of_run    = (wr_left_reg == 8'd1);
                        res_item.status         = status_reg;
                        res_item.produced_count = 24'(out_pos_reg + L'(1));
                        pack_data_next          = '0;
                        pack_n_next             = '0;
                    end else begin
                        pack_data_next = pack_ins;
                        pack_n_next    = pack_cnt;
                    end
                    if (wr_left_reg == 8'd1) begin
                        state_next = S_IDLE;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        if (res_push) begin
            m_valid_next = 1'b1;
            m_item_next  = res_item;
        end else begin
            m_valid_next = m_valid_reg && !m_ready;
            m_item_next  = m_item_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= S_IDLE;
            in_start_reg     <= 1'b0;
            status_reg       <= lzsq_pkg::STATUS_RUNNING;
            phase_reg        <= lzsq_pkg::PH_FIRST;
            in_pos_reg       <= '0;
            out_pos_reg      <= '0;
            wptr_reg         <= '0;
            token_first_reg  <= 8'd0;
            dist_reg         <= '0;
            literal_left_reg <= 8'd0;
            src_len_reg      <= '0;
            dst_len_reg      <= '0;
            rd_left_reg      <= 8'd0;
            wr_left_reg      <= 8'd0;
            b_valid_reg      <= 1'b0;
            any_done_reg     <= 1'b0;
            pack_n_reg       <= '0;
            m_valid_reg      <= 1'b0;
        end else begin
            state_reg        <= state_next;
            in_start_reg     <= in_start_next;
            status_reg       <= status_next;
            phase_reg        <= phase_next;
            in_pos_reg       <= in_pos_next;
            out_pos_reg      <= out_pos_next;
            wptr_reg         <= wptr_next;
            token_first_reg  <= token_first_next;
            dist_reg         <= dist_next;
            literal_left_reg <= literal_left_next;
            src_len_reg      <= src_len_next;
            dst_len_reg      <= dst_len_next;
            rd_left_reg      <= rd_left_next;
            wr_left_reg      <= wr_left_next;
            b_valid_reg      <= b_valid_next;
            any_done_reg     <= any_done_next;
            pack_n_reg       <= pack_n_next;
            m_valid_reg      <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        in_byte_reg    <= in_byte_next;
        rd_addr_reg    <= rd_addr_next;
        fwd_one_reg    <= fwd_one_next;
        last_byte_reg  <= last_byte_next;
        pack_data_reg  <= pack_data_next;
        m_item_reg     <= m_item_next;
    end

    // history: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            history_mem[mem_waddr] <= mem_wdata;
        end
        if (rd_en) begin
            rdata_reg <= history_mem[rd_addr_reg];
        end
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    // at most one history read in flight during a copy
    a_copy_inflight: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_COPY) |-> (9'(wr_left_reg) == 9'(rd_left_reg) + 9'(b_valid_reg)))
        else $error("copy read and write counts out of step");

    a_copy_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_COPY) |-> (wr_left_reg != 8'd0))
        else $error("copy state with nothing left to write");

    a_read_beat_in_copy: assert property (@(posedge aclk) disable iff (!aresetn)
        b_valid_reg |-> (state_reg == S_COPY))
        else $error("history read data pending outside a copy");

    a_push_room: assert property (@(posedge aclk) disable iff (!aresetn)
        res_push |-> out_free)
        else $error("result pushed into an occupied output stage");

    a_pack_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_COPY) |=> ((state_reg != S_COPY) || (pack_n_reg == '0)))
        else $error("copy entered with a partly packed result");

endmodule
